>>> design/rir_pkg.sv
// Shared types, constants and helper functions for the rational image rescaler.
// Used by the controller, the datapath, the line RAM and the top level.
package rir_pkg;

  localparam int CHANNEL_BITS       = 8;
  localparam int SUM_BITS           = CHANNEL_BITS + 6;
  localparam int NUM_CH             = 3;
  localparam int MAX_SOURCE_COLUMNS = 1024;
  localparam int MAX_FACTOR         = 8;
  localparam int ROW_LIMIT          = 4096;
  localparam int SPAN               = MAX_SOURCE_COLUMNS * MAX_FACTOR;
  localparam int SPAN_AW            = $clog2(SPAN);
  localparam int SLOT_AW            = $clog2(MAX_FACTOR);
  localparam int LINE_WIDTH         = NUM_CH * SUM_BITS;
  localparam int CFG_IDX_BITS       = 2;
  localparam int CFG_DATA_BITS      = 13;
  localparam int RECIP_D_BITS       = 20;
  localparam int RECIP_D_SHIFT      = 19;
  localparam int RECIP_DD_BITS      = 21;
  localparam int RECIP_DD_SHIFT     = 20;
  localparam logic [2:0] DIV_STEPS  = 3'd6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_UP_FACTOR      = 2'd0,
    CFG_DOWN_FACTOR    = 2'd1,
    CFG_SOURCE_COLUMNS = 2'd2,
    CFG_SOURCE_ROWS    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    DIV_ROWS_OUT = 3'd0,
    DIV_COLS_OUT = 3'd1,
    DIV_R0       = 3'd2,
    DIV_REND     = 3'd3,
    DIV_C0       = 3'd4,
    DIV_CEND     = 3'd5
  } div_sel_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [14:0] out_row;
    logic [12:0] out_column;
    logic        last_of_run;
  } out_pixel_t;

  typedef struct packed {
    logic     clear;
    logic     accept;
    logic     div_issue;
    logic     div_store;
    div_sel_e div_sel;
    logic     base;
    logic     pt0;
    logic     next_row;
    logic     pt1;
    logic     pt2;
    logic     emit;
    logic     finish;
  } rir_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic row_ok;
    logic col_ok;
    logic emits;
    logic out_free;
    logic pend_valid;
  } rir_stat_t;

  function automatic logic [3:0] eff_factor(input logic [3:0] f);
    logic [3:0] r;
    if (f == 4'd0) r = 4'd1;
    else if (f > 4'(MAX_FACTOR)) r = 4'(MAX_FACTOR);
    else r = f;
    return r;
  endfunction

  // ceil(2^19 / d): exact quotient for dividends below 2^16
  function automatic logic [RECIP_D_BITS-1:0] recip_d(input logic [3:0] d);
    logic [RECIP_D_BITS-1:0] r;
    unique case (d)
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd5:    r = 20'd104858;
      4'd6:    r = 20'd87382;
      4'd7:    r = 20'd74899;
      4'd8:    r = 20'd65536;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

  // ceil(2^20 / d^2): exact quotient for dividends below 2^14
  function automatic logic [RECIP_DD_BITS-1:0] recip_dd(input logic [3:0] d);
    logic [RECIP_DD_BITS-1:0] r;
    unique case (d)
      4'd2:    r = 21'd262144;
      4'd3:    r = 21'd116509;
      4'd4:    r = 21'd65536;
      4'd5:    r = 21'd41944;
      4'd6:    r = 21'd29128;
      4'd7:    r = 21'd21400;
      4'd8:    r = 21'd16384;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

>>> design/rational_image_rescaler_core.sv
// Rational image rescaler top level: controller, datapath and line-sum RAM.
// One request at a time: six reciprocal divides for setup, then per target point the
// states PT0, PT1 (plus PT2, EMIT for a result), a row step per target row, DONE last.
// A result is held one result behind and goes out with the next result or at the close.
// After reset a clearing pass zeroes the line sums; no request is taken until it ends.
module rational_image_rescaler_core import rir_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_pixel_t                in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_pixel_t               out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  rir_cmd_t              cmd;
  rir_stat_t             stat;
  logic                  ram_we;
  logic [SPAN_AW-1:0]    ram_waddr, ram_raddr;
  logic [LINE_WIDTH-1:0] ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  rir_ram #(
    .WIDTH(LINE_WIDTH),
    .DEPTH(SPAN)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rir_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one still in work");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.pend_valid)
    else $error("pending result left behind at request end");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!stat.pend_valid || stat.out_free))
    else $error("result overwritten before hand-off");

endmodule

>>> design/rir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on rir_pkg for default sizes.
module rir_ram import rir_pkg::*; #(
  parameter int WIDTH = LINE_WIDTH,
  parameter int DEPTH = SPAN
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rir_ctrl.sv
// Sequencer for the rescaler: clearing pass, per-request divide sequence,
// target point loop and result hand-off. Depends on rir_pkg.
module rir_ctrl import rir_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rir_stat_t stat_i,
  output rir_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_BASE  = 9'b000001000,
    ST_PT0   = 9'b000010000,
    ST_PT1   = 9'b000100000,
    ST_PT2   = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [2:0]  div_cnt_q, div_cnt_d;
  logic        slot_ok;

  assign slot_ok = !stat_i.pend_valid || stat_i.out_free;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    cmd_o.div_sel = div_sel_e'(div_cnt_q);
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          div_cnt_d    = 3'd0;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        // issue one divide a cycle, store the previous one's quotient
        cmd_o.div_issue = (div_cnt_q != DIV_STEPS);
        cmd_o.div_store = (div_cnt_q != 3'd0);
        div_cnt_d = div_cnt_q + 3'd1;
        if (div_cnt_q == DIV_STEPS) state_d = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_PT0;
      end
      ST_PT0: begin
        if (!stat_i.row_ok) begin
          state_d = ST_DONE;
        end else if (!stat_i.col_ok) begin
          cmd_o.next_row = 1'b1;
        end else begin
          cmd_o.pt0 = 1'b1;
          state_d   = ST_PT1;
        end
      end
      ST_PT1: begin
        cmd_o.pt1 = 1'b1;
        state_d   = stat_i.emits ? ST_PT2 : ST_PT0;
      end
      ST_PT2: begin
        cmd_o.pt2 = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_PT0;
        end
      end
      ST_DONE: begin
        if (slot_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      div_cnt_q <= 3'd0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

>>> design/rir_dp.sv
// Datapath of the rescaler: configuration registers, source position,
// reciprocal dividers, box sums and the result registers. Depends on rir_pkg.
module rir_dp import rir_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  in_pixel_t                in_data_i,
  output out_pixel_t               out_data_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  rir_cmd_t                 cmd_i,
  output rir_stat_t                stat_o,
  output logic                     ram_we_o,
  output logic [SPAN_AW-1:0]       ram_waddr_o,
  output logic [LINE_WIDTH-1:0]    ram_wdata_o,
  output logic [SPAN_AW-1:0]       ram_raddr_o,
  input  logic [LINE_WIDTH-1:0]    ram_rdata_i
);

  // configuration and position
  logic [3:0]  up_q, down_q;
  logic [10:0] cols_q;
  logic [12:0] rows_q;
  logic [11:0] row_cnt_q;
  logic [9:0]  col_cnt_q;
  logic [3:0]  u_eff, d_eff;
  logic [10:0] cols_eff;
  logic [12:0] rows_eff;

  // per-request context
  in_pixel_t   pix_q;
  logic [3:0]  u_q, d_q;
  logic [15:0] rows_u_q;
  logic [13:0] cols_u_q;
  logic [14:0] rtop_q, rbot;
  logic [12:0] ctop_q, cbot;

  // divider
  logic [15:0] div_op;
  logic [35:0] div_prod;
  logic [15:0] div_res_q;
  div_sel_e    div_tag_q;
  logic [15:0] rows_out_q;
  logic [13:0] cols_out_q;
  logic [14:0] r0_q, rend_q;
  logic [12:0] c0_q, cend_q;

  // point loop
  logic [15:0] r_q, rd_q, rd_end, rlo, rhi, wr_full, rtop16, rbot16;
  logic [13:0] c_q, cd_q, c0d_q, cd_end, clo, chi, wc_full, ctop14, cbot14;
  logic [6:0]  w_q;
  logic [SLOT_AW-1:0] k_q;
  logic [15:0] k_full;
  logic        cs_q, cgo_q, rs_q, rgo_q, emits_q;
  logic [LINE_WIDTH-1:0] colsum_q [MAX_FACTOR];
  logic [LINE_WIDTH-1:0] t_vec, t2_vec, sum_q;
  logic [12:0] res_col_q;
  logic [7:0]  q_q [NUM_CH];
  logic [7:0]  q_d [NUM_CH];
  logic [CHANNEL_BITS-1:0] pix_ch [NUM_CH];

  // results
  out_pixel_t  pend_q, out_q, new_res;
  logic        pend_valid_q, out_valid_q, out_free, push;
  logic [SPAN_AW-1:0] clr_addr_q;

  assign u_eff    = eff_factor(up_q);
  assign d_eff    = eff_factor(down_q);
  assign cols_eff = (cols_q == 11'd0) ? 11'd1 :
                    (cols_q > 11'(MAX_SOURCE_COLUMNS)) ? 11'(MAX_SOURCE_COLUMNS) : cols_q;
  assign rows_eff = (rows_q == 13'd0) ? 13'd1 :
                    (rows_q > 13'(ROW_LIMIT)) ? 13'(ROW_LIMIT) : rows_q;

  assign rbot   = rtop_q + {11'd0, u_q} - 15'd1;
  assign cbot   = ctop_q + {9'd0, u_q} - 13'd1;
  assign rtop16 = {1'b0, rtop_q};
  assign rbot16 = {1'b0, rbot};
  assign ctop14 = {1'b0, ctop_q};
  assign cbot14 = {1'b0, cbot};

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_ROWS_OUT: div_op = rows_u_q;
      DIV_COLS_OUT: div_op = {2'd0, cols_u_q};
      DIV_R0:       div_op = {1'b0, rtop_q};
      DIV_REND:     div_op = {1'b0, rbot};
      DIV_C0:       div_op = {3'd0, ctop_q};
      DIV_CEND:     div_op = {3'd0, cbot};
      default:      div_op = 16'd0;
    endcase
  end
  assign div_prod = {20'd0, div_op} * {16'd0, recip_d(d_q)};

  // overlap of the target box with this pixel's upsampled block
  assign rd_end  = rd_q + {12'd0, d_q} - 16'd1;
  assign rlo     = (rd_q > rtop16) ? rd_q : rtop16;
  assign rhi     = (rd_end < rbot16) ? rd_end : rbot16;
  assign wr_full = rhi - rlo + 16'd1;
  assign cd_end  = cd_q + {10'd0, d_q} - 14'd1;
  assign clo     = (cd_q > ctop14) ? cd_q : ctop14;
  assign chi     = (cd_end < cbot14) ? cd_end : cbot14;
  assign wc_full = chi - clo + 14'd1;
  assign k_full  = r_q - {1'b0, r0_q};

  assign pix_ch[0] = pix_q.in_red;
  assign pix_ch[1] = pix_q.in_green;
  assign pix_ch[2] = pix_q.in_blue;

  always_comb begin
    logic [14:0] prod;
    logic [SUM_BITS-1:0] t, t2;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod = {8'd0, w_q} * {7'd0, pix_ch[ch]};
      t  = prod[SUM_BITS-1:0]
         + (cs_q ? colsum_q[k_q][ch*SUM_BITS +: SUM_BITS] : {SUM_BITS{1'b0}});
      t2 = t + (rs_q ? ram_rdata_i[ch*SUM_BITS +: SUM_BITS] : {SUM_BITS{1'b0}});
      t_vec[ch*SUM_BITS +: SUM_BITS]  = t;
      t2_vec[ch*SUM_BITS +: SUM_BITS] = t2;
    end
  end

  always_comb begin
    logic [34:0] qp;
    logic [13:0] qv;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      qp = {21'd0, sum_q[ch*SUM_BITS +: SUM_BITS]} * {14'd0, recip_dd(d_q)};
      qv = qp[33:20];
      q_d[ch] = (qv > 14'd255) ? 8'hFF : qv[7:0];
    end
  end

  assign new_res = '{out_red: q_q[0], out_green: q_q[1], out_blue: q_q[2],
                     out_row: r_q[14:0], out_column: res_col_q, last_of_run: 1'b0};

  assign out_free = !out_valid_q || out_ready_i;
  assign push     = (cmd_i.emit || cmd_i.finish) && pend_valid_q;

  assign ram_we_o    = cmd_i.clear || (cmd_i.pt1 && !cgo_q && rgo_q);
  assign ram_waddr_o = cmd_i.clear ? clr_addr_q : c_q[SPAN_AW-1:0];
  assign ram_wdata_o = cmd_i.clear ? {LINE_WIDTH{1'b0}} : t2_vec;
  assign ram_raddr_o = c_q[SPAN_AW-1:0];

  assign stat_o.clear_last = (clr_addr_q == SPAN_AW'(SPAN - 1));
  assign stat_o.row_ok     = (r_q <= {1'b0, rend_q}) && (r_q < rows_out_q);
  assign stat_o.col_ok     = (c_q <= {1'b0, cend_q}) && (c_q < cols_out_q);
  assign stat_o.emits      = emits_q;
  assign stat_o.out_free   = out_free;
  assign stat_o.pend_valid = pend_valid_q;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q         <= 4'd1;
      down_q       <= 4'd1;
      cols_q       <= 11'd1;
      rows_q       <= 13'd1;
      row_cnt_q    <= 12'd0;
      col_cnt_q    <= 10'd0;
      clr_addr_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_FACTOR; i++) colsum_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_UP_FACTOR:      up_q   <= cfg_data_i[3:0];
          CFG_DOWN_FACTOR:    down_q <= cfg_data_i[3:0];
          CFG_SOURCE_COLUMNS: cols_q <= cfg_data_i[10:0];
          CFG_SOURCE_ROWS:    rows_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + SPAN_AW'(1);
      if (cmd_i.pt1 && cgo_q) colsum_q[k_q] <= t_vec;
      if (push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.emit) pend_valid_q <= 1'b1;
      else if (cmd_i.finish) pend_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        // advance to the next source pixel, wrap at row and frame end
        if ({1'b0, col_cnt_q} + 11'd1 >= cols_eff) begin
          col_cnt_q <= 10'd0;
          if ({1'b0, row_cnt_q} + 13'd1 >= rows_eff) row_cnt_q <= 12'd0;
          else row_cnt_q <= row_cnt_q + 12'd1;
        end else begin
          col_cnt_q <= col_cnt_q + 10'd1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q    <= in_data_i;
      u_q      <= u_eff;
      d_q      <= d_eff;
      rows_u_q <= {3'd0, rows_eff} * {12'd0, u_eff};
      cols_u_q <= {3'd0, cols_eff} * {10'd0, u_eff};
      rtop_q   <= {3'd0, row_cnt_q} * {11'd0, u_eff};
      ctop_q   <= {3'd0, col_cnt_q} * {9'd0, u_eff};
    end
    if (cmd_i.div_issue) begin
      div_res_q <= div_prod[34:19];
      div_tag_q <= cmd_i.div_sel;
    end
    if (cmd_i.div_store) begin
      unique case (div_tag_q)
        DIV_ROWS_OUT: rows_out_q <= div_res_q;
        DIV_COLS_OUT: cols_out_q <= div_res_q[13:0];
        DIV_R0:       r0_q       <= div_res_q[14:0];
        DIV_REND:     rend_q     <= div_res_q[14:0];
        DIV_C0:       c0_q       <= div_res_q[12:0];
        DIV_CEND:     cend_q     <= div_res_q[12:0];
        default:      ;
      endcase
    end
    if (cmd_i.base) begin
      r_q   <= {1'b0, r0_q};
      rd_q  <= 16'({1'b0, r0_q} * {12'd0, d_q});
      c_q   <= {1'b0, c0_q};
      cd_q  <= 14'({1'b0, c0_q} * {10'd0, d_q});
      c0d_q <= 14'({1'b0, c0_q} * {10'd0, d_q});
    end
    if (cmd_i.next_row) begin
      r_q  <= r_q + 16'd1;
      rd_q <= rd_q + {12'd0, d_q};
      c_q  <= {1'b0, c0_q};
      cd_q <= c0d_q;
    end
    if (cmd_i.pt0) begin
      w_q     <= {3'd0, wr_full[3:0]} * {3'd0, wc_full[3:0]};
      k_q     <= k_full[SLOT_AW-1:0];
      cs_q    <= cd_q < ctop14;
      cgo_q   <= cd_end > cbot14;
      rs_q    <= rd_q < rtop16;
      rgo_q   <= rd_end > rbot16;
      emits_q <= !(cd_end > cbot14) && !(rd_end > rbot16);
    end
    if (cmd_i.pt1) begin
      sum_q     <= t2_vec;
      res_col_q <= c_q[12:0];
      c_q       <= c_q + 14'd1;
      cd_q      <= cd_q + {10'd0, d_q};
    end
    if (cmd_i.pt2) begin
      for (int ch = 0; ch < NUM_CH; ch++) q_q[ch] <= q_d[ch];
    end
    if (cmd_i.emit) pend_q <= new_res;
    if (push) begin
      out_q             <= pend_q;
      out_q.last_of_run <= cmd_i.finish;
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for rational_image_rescaler_core: a pixel scoreboard
// predicts the rescaled pixels and checks each one. Depends on rir_pkg.
module testbench import rir_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_pixel_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_pixel_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  rational_image_rescaler_core uut (.*);

  always #10 clk_i = ~clk_i;

  // Scaler state as the block should hold it
  logic [3:0] up_reg, down_reg;
  logic [10:0] cols_reg;
  logic [12:0] rows_reg;
  logic [SUM_BITS-1:0] band_sum [SPAN][NUM_CH];
  logic [SUM_BITS-1:0] strip_sum [MAX_FACTOR+1][NUM_CH];
  int unsigned src_row, src_col;

  in_pixel_t pending_pixels[$];
  out_pixel_t expected_pixels[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit in_taken = 0, out_taken = 0, calm = 0, long_hold_go = 0;
  int in_gap = 0, out_stall = 0, hold_left = 0;

  function automatic int unsigned clamp_factor(logic [3:0] f);
    if (f == 0) return 1;
    return (f > MAX_FACTOR) ? MAX_FACTOR : f;
  endfunction

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned span_overlap(int unsigned a0, a1, b0, b1);
    int unsigned lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi >= lo) ? hi - lo + 1 : 0;
  endfunction

  function automatic void rescale_pixel(in_pixel_t px);
    int unsigned u, d, cols, rows, rows_out, cols_out, rtop, rbot, ctop, cbot;
    int unsigned k, wr, wc, q, n, row_idx, col_idx;
    int unsigned val [NUM_CH];
    int unsigned acc [NUM_CH];
    bit row_started, row_goes_on, col_started, col_goes_on;
    out_pixel_t o;
    u = clamp_factor(up_reg);
    d = clamp_factor(down_reg);
    cols = clamp_size(cols_reg, MAX_SOURCE_COLUMNS);
    rows = clamp_size(rows_reg, ROW_LIMIT);
    rows_out = rows * u / d;
    cols_out = cols * u / d;
    rtop = src_row * u; rbot = rtop + u - 1;
    ctop = src_col * u; cbot = ctop + u - 1;
    val[0] = px.in_red; val[1] = px.in_green; val[2] = px.in_blue;
    n = 0;
    for (row_idx = rtop / d; row_idx <= rbot / d && row_idx < rows_out; row_idx++) begin
      k = row_idx - rtop / d;
      wr = span_overlap(row_idx * d, row_idx * d + d - 1, rtop, rbot);
      row_started = row_idx * d < rtop;
      row_goes_on = row_idx * d + d - 1 > rbot;
      if (k > MAX_FACTOR) break;
      for (col_idx = ctop / d; col_idx <= cbot / d && col_idx < cols_out; col_idx++) begin
        wc = span_overlap(col_idx * d, col_idx * d + d - 1, ctop, cbot);
        col_started = col_idx * d < ctop;
        col_goes_on = col_idx * d + d - 1 > cbot;
        if (col_idx >= SPAN) break;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          acc[ch] = wr * wc * val[ch];
          if (col_started) acc[ch] += strip_sum[k][ch];
          acc[ch] &= (1 << SUM_BITS) - 1;
        end
        if (col_goes_on) begin
          for (int ch = 0; ch < NUM_CH; ch++) strip_sum[k][ch] = acc[ch];
          continue;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (row_started) acc[ch] += band_sum[col_idx][ch];
          acc[ch] &= (1 << SUM_BITS) - 1;
        end
        if (row_goes_on) begin
          for (int ch = 0; ch < NUM_CH; ch++) band_sum[col_idx][ch] = acc[ch];
          continue;
        end
        if (n < 64) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            q = acc[ch] / (d * d);
            val[ch] = val[ch];
            acc[ch] = (q > 255) ? 255 : q;
          end
          o.out_red = acc[0][7:0];
          o.out_green = acc[1][7:0];
          o.out_blue = acc[2][7:0];
          o.out_row = row_idx[14:0];
          o.out_column = col_idx[12:0];
          o.last_of_run = 1'b0;
          expected_pixels.push_back(o);
          n++;
        end
      end
    end
    if (n > 0) expected_pixels[$].last_of_run = 1'b1;
    src_col++;
    if (src_col >= cols) begin
      src_col = 0;
      src_row++;
      if (src_row >= rows) src_row = 0;
    end
    src_col &= 32'h3FF;
    src_row &= 32'hFFF;
  endfunction

  // Sample both channels and check results at the rising edge
  always @(posedge clk_i) begin
    out_pixel_t want;
    in_taken = in_valid_i && in_ready_o;
    out_taken = out_valid_o && out_ready_i;
    if (in_taken) rescale_pixel(in_data_i);
    if (out_taken) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %p", out_data_o);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("pixel mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  // Pixel driver: hold the request until taken, then advance after a gap
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_pixels.pop_front();
        in_gap <= calm ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off
  always @(negedge clk_i) begin
    if (long_hold_go) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
    end else if (out_taken) begin
      out_stall = calm ? 0 : $urandom_range(0, 5);
      out_ready_i <= (out_stall == 0);
    end else if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ready_i <= (out_stall == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_pixels.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CFG_DATA_BITS-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_UP_FACTOR:      up_reg = value[3:0];
      CFG_DOWN_FACTOR:    down_reg = value[3:0];
      CFG_SOURCE_COLUMNS: cols_reg = value[10:0];
      default:            rows_reg = value[12:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(int unsigned u, d, cols, rows);
    wait_idle();
    write_reg(CFG_UP_FACTOR, u);
    write_reg(CFG_DOWN_FACTOR, d);
    write_reg(CFG_SOURCE_COLUMNS, cols);
    write_reg(CFG_SOURCE_ROWS, rows);
  endtask

  function automatic in_pixel_t random_pixel();
    in_pixel_t p;
    p = in_pixel_t'(24'($urandom));
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int unsigned sent, u, d, cols, rows, frames, phase;
    up_reg = 1; down_reg = 1; cols_reg = 1; rows_reg = 1;
    src_row = 0; src_col = 0;
    foreach (band_sum[i, ch]) band_sum[i][ch] = '0;
    foreach (strip_sum[i, ch]) strip_sum[i][ch] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values and the extremes of the channels
    pending_pixels.push_back('0);
    pending_pixels.push_back('1);
    pending_pixels.push_back({8'hAA, 8'h55, 8'hF0});
    // Zero factors and zero sizes act as one
    configure(0, 0, 0, 0);
    pending_pixels.push_back({8'h0F, 8'hFF, 8'h00});
    pending_pixels.push_back({8'hFF, 8'h00, 8'h81});
    // Largest up factor: a full 8x8 run from each pixel
    configure(15, 1, 1, 1);
    pending_pixels.push_back('1);
    pending_pixels.push_back({8'h12, 8'h34, 8'h56});
    // Oversized frame, left mid-frame for the following change
    configure(1, 1, 2047, 8191);
    repeat (4) pending_pixels.push_back(random_pixel());
    // New limits mid-frame: the counts wrap, stale sums remain
    configure(3, 2, 3, 2);
    repeat (7) pending_pixels.push_back(random_pixel());
    // Largest down factor against largest up factor
    configure(8, 8, 2, 2);
    repeat (4) pending_pixels.push_back('1);
    sent = 22;

    phase = 0;
    while (sent < 320) begin
      u = $urandom_range(1, 8);
      d = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) u = $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 15);
      cols = $urandom_range(1, 6);
      rows = $urandom_range(1, 4);
      configure(u, d, cols, rows);
      calm = (phase % 5 == 4);
      if (phase == 2) begin
        long_hold_go = 1;
        @(posedge clk_i);
        long_hold_go = 0;
      end
      frames = $urandom_range(1, 2);
      repeat (frames * cols * rows) pending_pixels.push_back(random_pixel());
      sent += frames * cols * rows;
      phase++;
    end

    wait_idle();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
